/* src/gtc_pkg.sv */
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and constants for the grind timer controller.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int unsigned ITEM_DATA_W = 24;
    localparam int unsigned ITEM_USER_W = 2;
    localparam int unsigned RES_DATA_W  = 40;

    localparam logic [31:0] SINGLE_DEFAULT = 32'd9300;
    localparam logic [31:0] DOUBLE_DEFAULT = 32'd13700;
    localparam logic [31:0] WRAP_LIMIT     = 32'd100000;
    localparam logic [31:0] REMOTE_STEP    = 32'd100;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_PLUS  = 2'd1;
    localparam logic [1:0] MODE_MINUS = 2'd2;
    localparam logic [1:0] MODE_PAGE  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        grind_button;
        logic        up_button;
        logic        down_button;
        logic [15:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic        grind_drive;
        logic        page_now;
        logic [31:0] time_ms;
        logic        redraw_req;
        logic        refresh_req;
        logic        save_strobe;
    } t_result;

    typedef struct packed {
        logic        grinding;
        logic        programming;
        logic        page;
        logic [31:0] cur_time;
        logic [31:0] single_time;
        logic [31:0] double_time;
        logic        prev_grind;
        logic        prev_up;
        logic        prev_down;
    } t_state;

endpackage

/* src/gtc_in_stage.sv */
// ----------------------------------------------------------------------------
// gtc_in_stage
// Input register holding one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module gtc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gtc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output gtc_pkg::t_item o_item
);

    logic           r_valid;
    gtc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/gtc_core.sv */
// ----------------------------------------------------------------------------
// gtc_core
// Controller state and the per-item decision chain.
// ----------------------------------------------------------------------------
module gtc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  gtc_pkg::t_item   i_item,
    output gtc_pkg::t_result o_result
);

    gtc_pkg::t_state r_st;
    gtc_pkg::t_state n_st;

    always_comb begin
        logic        g;
        logic        u;
        logic        d;
        logic        none;
        logic [31:0] dec;
        logic        redraw;
        logic        refresh;
        logic        save;

        g       = i_item.grind_button;
        u       = i_item.up_button;
        d       = i_item.down_button;
        none    = !g && !u && !d;
        dec     = r_st.cur_time - {16'd0, i_item.elapsed_ms};
        redraw  = 1'b0;
        refresh = 1'b0;
        save    = 1'b0;
        n_st    = r_st;

        case (i_item.mode)
            gtc_pkg::MODE_TICK: begin
                if (g && !r_st.prev_grind && (u ^ d) && !r_st.programming) begin
                    n_st.programming = 1'b1;
                    n_st.cur_time    = 32'd0;
                end else if (r_st.programming && none && (r_st.prev_up || r_st.prev_down)) begin
                    n_st.programming = 1'b0;
                    if (!r_st.page) begin
                        n_st.single_time = r_st.cur_time;
                    end else begin
                        n_st.double_time = r_st.cur_time;
                    end
                    save   = 1'b1;
                    redraw = 1'b1;
                end else if (r_st.programming && g) begin
                    n_st.grinding = 1'b1;
                    n_st.cur_time = r_st.cur_time + {16'd0, i_item.elapsed_ms};
                    refresh       = 1'b1;
                end else if (r_st.programming) begin
                    n_st.grinding = 1'b0;
                end else if (g && (r_st.cur_time != 32'd0) && !u && !d) begin
                    if (dec > gtc_pkg::WRAP_LIMIT) begin
                        n_st.cur_time = 32'd0;
                        n_st.grinding = 1'b0;
                        redraw        = 1'b1;
                    end else begin
                        n_st.cur_time = dec;
                        n_st.grinding = 1'b1;
                        refresh       = 1'b1;
                    end
                end else if (!r_st.grinding && none && (r_st.prev_up || r_st.prev_down)) begin
                    n_st.page     = !r_st.page;
                    n_st.cur_time = r_st.page ? r_st.single_time : r_st.double_time;
                    redraw        = 1'b1;
                end else if (none && r_st.prev_grind && (r_st.cur_time == 32'd0)) begin
                    n_st.cur_time = r_st.page ? r_st.double_time : r_st.single_time;
                    redraw        = 1'b1;
                end else begin
                    n_st.grinding    = 1'b0;
                    n_st.programming = 1'b0;
                end
                n_st.prev_grind = g;
                n_st.prev_up    = u;
                n_st.prev_down  = d;
            end
            gtc_pkg::MODE_PLUS: begin
                n_st.cur_time = r_st.cur_time + gtc_pkg::REMOTE_STEP;
                refresh       = 1'b1;
            end
            gtc_pkg::MODE_MINUS: begin
                n_st.cur_time = r_st.cur_time - gtc_pkg::REMOTE_STEP;
                refresh       = 1'b1;
            end
            default: begin
                n_st.page     = !r_st.page;
                n_st.cur_time = r_st.page ? r_st.single_time : r_st.double_time;
                redraw        = 1'b1;
            end
        endcase

        o_result.grind_drive = n_st.grinding;
        o_result.page_now    = n_st.page;
        o_result.time_ms     = n_st.cur_time;
        o_result.redraw_req  = redraw;
        o_result.refresh_req = refresh;
        o_result.save_strobe = save;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.grinding    <= 1'b0;
            r_st.programming <= 1'b0;
            r_st.page        <= 1'b0;
            r_st.cur_time    <= gtc_pkg::SINGLE_DEFAULT;
            r_st.single_time <= gtc_pkg::SINGLE_DEFAULT;
            r_st.double_time <= gtc_pkg::DOUBLE_DEFAULT;
            r_st.prev_grind  <= 1'b0;
            r_st.prev_up     <= 1'b0;
            r_st.prev_down   <= 1'b0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

endmodule

/* src/gtc_out_stage.sv */
// ----------------------------------------------------------------------------
// gtc_out_stage
// Result register between the core and the output stream.
// ----------------------------------------------------------------------------
module gtc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gtc_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output gtc_pkg::t_result o_result
);

    logic             r_valid;
    gtc_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* src/grind_timer_controller.sv */
// ----------------------------------------------------------------------------
// grind_timer_controller
// Grinder timer: button ticks and remote actions in, motor level, page,
// time and screen requests out.
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   grind, up, down, elapsed_ms             mode
//   m_axis   out  drive, page, time_ms, redraw, refresh,  -
//                 save
//
// One item per cycle sustained while the output takes every result; an item is
// held in the input register, then its result in the result register, before
// the result is offered on m_axis.
// Synchronous active-low reset restores the default shot times and page.
// A stalled output holds its result while one more item waits in the
// input register; the core advances only when the result register is free.
// ----------------------------------------------------------------------------
module grind_timer_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // grind_button, up_button, down_button, elapsed_ms[15:0], zero pad
    input  logic [gtc_pkg::ITEM_DATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  logic [gtc_pkg::ITEM_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // grind_drive, page_now, time_ms[31:0], redraw_req, refresh_req,
    // save_strobe, zero pad
    output logic [gtc_pkg::RES_DATA_W-1:0]    m_axis_tdata
);

    gtc_pkg::t_item   in_item;
    gtc_pkg::t_item   held_item;
    gtc_pkg::t_result core_result;
    gtc_pkg::t_result out_result;
    logic             held_valid;
    logic             out_space;
    logic             fire;

    assign in_item.mode         = s_axis_tuser;
    assign in_item.grind_button = s_axis_tdata[0];
    assign in_item.up_button    = s_axis_tdata[1];
    assign in_item.down_button  = s_axis_tdata[2];
    assign in_item.elapsed_ms   = s_axis_tdata[18:3];

    assign fire = held_valid && out_space;

    gtc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    gtc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (core_result)
    );

    gtc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {3'd0,
                           out_result.save_strobe,
                           out_result.refresh_req,
                           out_result.redraw_req,
                           out_result.time_ms,
                           out_result.page_now,
                           out_result.grind_drive};

endmodule

/* bench/timer_result_check.sv */
// ----------------------------------------------------------------------------
// timer_result_check
// Watches both streams of the grind timer controller. Every accepted item
// advances an independent model of the timer state and queues the result it
// should produce; every accepted result is compared field by field against
// the oldest queued one. Mismatch and outstanding counts go to the bench top.
// ----------------------------------------------------------------------------
module timer_result_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // grind_button, up_button, down_button, elapsed_ms[15:0], zero pad
    input  logic [gtc_pkg::ITEM_DATA_W-1:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [gtc_pkg::ITEM_USER_W-1:0] i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // grind_drive, page_now, time_ms[31:0], redraw_req, refresh_req,
    // save_strobe, zero pad
    input  logic [gtc_pkg::RES_DATA_W-1:0]  i_m_axis_tdata,
    output int                              o_bad_results,
    output int                              o_results_owed
);
    import gtc_pkg::*;

    logic        gr_active;
    logic        prog_active;
    logic        page_sel;
    logic [31:0] time_now;
    logic [31:0] shot_single;
    logic [31:0] shot_double;
    logic        last_g;
    logic        last_u;
    logic        last_d;

    t_result due_results[$];

    initial begin
        o_bad_results  = 0;
        o_results_owed = 0;
    end

    function automatic void flip_page(ref t_result r);
        page_sel = ~page_sel;
        time_now = page_sel ? shot_double : shot_single;
        r.redraw_req = 1'b1;
    endfunction

    function automatic t_result advance_timer(input t_item it);
        t_result r;
        logic    g, u, d, none;
        r    = '0;
        g    = it.grind_button;
        u    = it.up_button;
        d    = it.down_button;
        none = !g && !u && !d;
        case (it.mode)
            MODE_TICK: begin
                if (g && !last_g && (u ^ d) && !prog_active) begin
                    prog_active = 1'b1;
                    time_now    = '0;
                end else if (prog_active && none && (last_u || last_d)) begin
                    prog_active = 1'b0;
                    if (page_sel) shot_double = time_now;
                    else          shot_single = time_now;
                    r.save_strobe = 1'b1;
                    r.redraw_req  = 1'b1;
                end else if (prog_active && g) begin
                    gr_active     = 1'b1;
                    time_now      = time_now + 32'(it.elapsed_ms);
                    r.refresh_req = 1'b1;
                end else if (prog_active) begin
                    gr_active = 1'b0;
                end else if (g && time_now != 0 && !u && !d) begin
                    gr_active     = 1'b1;
                    time_now      = time_now - 32'(it.elapsed_ms);
                    r.refresh_req = 1'b1;
                    // countdown ran past zero
                    if (time_now > WRAP_LIMIT) begin
                        time_now      = '0;
                        gr_active     = 1'b0;
                        r.refresh_req = 1'b0;
                        r.redraw_req  = 1'b1;
                    end
                end else if (!gr_active && none && (last_u || last_d)) begin
                    flip_page(r);
                end else if (!g && last_g && time_now == 0 && !u && !d) begin
                    time_now     = page_sel ? shot_double : shot_single;
                    r.redraw_req = 1'b1;
                end else begin
                    gr_active   = 1'b0;
                    prog_active = 1'b0;
                end
                last_g = g;
                last_u = u;
                last_d = d;
            end
            MODE_PLUS: begin
                time_now      = time_now + REMOTE_STEP;
                r.refresh_req = 1'b1;
            end
            MODE_MINUS: begin
                time_now      = time_now - REMOTE_STEP;
                r.refresh_req = 1'b1;
            end
            default: begin
                flip_page(r);
            end
        endcase
        r.grind_drive = gr_active;
        r.page_now    = page_sel;
        r.time_ms     = time_now;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("drive=%0b page=%0b time=%0d redraw=%0b refresh=%0b save=%0b",
                         r.grind_drive, r.page_now, r.time_ms, r.redraw_req,
                         r.refresh_req, r.save_strobe);
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            gr_active   = 1'b0;
            prog_active = 1'b0;
            page_sel    = 1'b0;
            time_now    = SINGLE_DEFAULT;
            shot_single = SINGLE_DEFAULT;
            shot_double = DOUBLE_DEFAULT;
            last_g      = 1'b0;
            last_u      = 1'b0;
            last_d      = 1'b0;
            due_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                it.mode         = i_s_axis_tuser[1:0];
                it.grind_button = i_s_axis_tdata[0];
                it.up_button    = i_s_axis_tdata[1];
                it.down_button  = i_s_axis_tdata[2];
                it.elapsed_ms   = i_s_axis_tdata[18:3];
                due_results.push_back(advance_timer(it));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.grind_drive = i_m_axis_tdata[0];
                got.page_now    = i_m_axis_tdata[1];
                got.time_ms     = i_m_axis_tdata[33:2];
                got.redraw_req  = i_m_axis_tdata[34];
                got.refresh_req = i_m_axis_tdata[35];
                got.save_strobe = i_m_axis_tdata[36];
                if (due_results.size() == 0) begin
                    o_bad_results = o_bad_results + 1;
                    if (o_bad_results <= 10)
                        $display("unexpected result: %s", show(got));
                end else begin
                    want = due_results.pop_front();
                    if (got.grind_drive !== want.grind_drive ||
                        got.page_now    !== want.page_now    ||
                        got.time_ms     !== want.time_ms     ||
                        got.redraw_req  !== want.redraw_req  ||
                        got.refresh_req !== want.refresh_req ||
                        got.save_strobe !== want.save_strobe) begin
                        o_bad_results = o_bad_results + 1;
                        if (o_bad_results <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
        end
        o_results_owed = due_results.size();
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the grind timer controller: a directed pass over
// grind, program, save, page and remote cases, then random button sequences
// under three idling patterns on both streams. Checking is done by
// timer_result_check.
// ----------------------------------------------------------------------------
module tb_top;
    import gtc_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // grind_button, up_button, down_button, elapsed_ms[15:0], zero pad
    logic [ITEM_DATA_W-1:0] s_axis_tdata  = '0;
    // mode[1:0]
    logic [ITEM_USER_W-1:0] s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // grind_drive, page_now, time_ms[31:0], redraw_req, refresh_req,
    // save_strobe, zero pad
    logic [RES_DATA_W-1:0]  m_axis_tdata;

    int bad_results;
    int results_owed;
    int items_sent  = 0;
    int tx_idle_pct = 28;
    int rx_idle_pct = 51;
    int quiet_count = 0;

    always #5 i_clk = ~i_clk;

    grind_timer_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    timer_result_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_bad_results   (bad_results),
        .o_results_owed  (results_owed)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n) begin
            quiet_count <= 0;
        end else if (quiet_count >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic g, input logic u,
                             input logic d, input logic [15:0] ms);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, ms, d, u, g};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick(input logic g, input logic u, input logic d, input logic [15:0] ms);
        send_item(MODE_TICK, g, u, d, ms);
    endtask

    // button fields ride along as noise
    task automatic remote(input logic [1:0] mode);
        send_item(mode, 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] step_ms(input int unsigned top);
        return 16'($urandom_range(top, 0));
    endfunction

    task automatic random_phase(input int n);
        int          target;
        int          reps;
        int unsigned top;
        logic        via_down;
        target = items_sent + n;
        while (items_sent < target) begin
            case ($urandom_range(2) )
                0:       top = 40;
                1:       top = 2500;
                default: top = ($urandom_range(3) == 0) ? 65535 : 400;
            endcase
            reps = $urandom_range(12, 1);
            case ($urandom_range(9))
                0, 1, 2: begin
                    // hold grind, then let go
                    tick(1'b0, 1'b0, 1'b0, step_ms(top));
                    repeat (reps) tick(1'b1, 1'b0, 1'b0, step_ms(top));
                    tick(1'b0, 1'b0, 1'b0, step_ms(top));
                end
                3, 4: begin
                    // program a new shot time
                    via_down = 1'($urandom);
                    tick(1'b0, 1'b0, 1'b0, step_ms(top));
                    repeat (reps) tick(1'b1, !via_down, via_down, step_ms(top));
                    if ($urandom_range(1)) tick(1'b0, !via_down, via_down, step_ms(top));
                    if ($urandom_range(7) != 0) tick(1'b0, 1'b0, 1'b0, step_ms(top));
                end
                5: begin
                    via_down = 1'($urandom);
                    repeat ($urandom_range(3, 1)) tick(1'b0, !via_down, via_down, step_ms(top));
                    tick(1'b0, 1'b0, 1'b0, step_ms(top));
                end
                6: begin
                    remote(2'($urandom_range(3, 1)));
                end
                default: begin
                    repeat ($urandom_range(3, 1))
                        send_item(($urandom_range(3) == 0) ? 2'($urandom) : MODE_TICK,
                                  1'($urandom), 1'($urandom), 1'($urandom),
                                  step_ms(top));
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed cases
        tick(1'b1, 1'b0, 1'b0, 16'd0);
        tick(1'b1, 1'b0, 1'b0, 16'hFFFF);
        tick(1'b0, 1'b0, 1'b0, 16'd0);
        tick(1'b1, 1'b1, 1'b0, 16'd5);
        tick(1'b1, 1'b1, 1'b0, 16'hFFFF);
        tick(1'b0, 1'b1, 1'b0, 16'd7);
        tick(1'b0, 1'b0, 1'b0, 16'd0);
        tick(1'b0, 1'b1, 1'b0, 16'd0);
        tick(1'b0, 1'b0, 1'b0, 16'd0);
        tick(1'b0, 1'b0, 1'b1, 16'h5555);
        tick(1'b0, 1'b0, 1'b0, 16'hAAAA);
        remote(MODE_PAGE);
        tick(1'b1, 1'b0, 1'b1, 16'd3);
        tick(1'b1, 1'b0, 1'b1, 16'd300);
        tick(1'b0, 1'b0, 1'b0, 16'd0);
        remote(MODE_MINUS);
        remote(MODE_MINUS);
        remote(MODE_MINUS);
        remote(MODE_MINUS);
        remote(MODE_PLUS);
        tick(1'b1, 1'b1, 1'b1, 16'hFFFF);
        tick(1'b1, 1'b0, 1'b0, 16'd100);
        tick(1'b0, 1'b0, 1'b0, 16'd0);
        tick(1'b1, 1'b0, 1'b0, 16'd300);
        tick(1'b0, 1'b0, 1'b0, 16'd1);

        random_phase(300);
        tx_idle_pct = 51;
        rx_idle_pct = 28;
        random_phase(300);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(300);

        s_axis_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (bad_results == 0 && results_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
